/* rtl/ray_box_slab_test_top_defines.svh */
// Assertion macros for the ray/box slab test block.
// Used by ray_box_slab_test_top; no other dependencies.
`ifndef RAY_BOX_SLAB_TEST_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RBST_ASSERT_IMPL(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("rbst assertion failed");
`define RBST_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("rbst assertion failed");
`else
`define RBST_ASSERT_IMPL(label, ant, cons)
`define RBST_ASSERT_NEXT(label, ant, cons)
`endif
`endif

/* rtl/rbst_pkg.sv */
// Shared types, constants and the plane distance finish function.
// No dependencies.
package rbst_pkg;
  localparam int VW = 32;
  localparam int DW = 33;
  localparam int QW = 33;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [VW-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VW-1:0] VMIN = 32'sh80000000;

  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

  typedef struct packed {
    logic dir_zero;
    logic num_pos;
    logic num_neg;
    logic q_neg;
  } side_t;

  function automatic logic signed [VW-1:0] plane_t(input logic [QW-1:0] q, input logic ovf,
                                                   input side_t sd, input logic zero_is_max);
    logic [QW-1:0] qn;
    logic signed [VW-1:0] r;
    qn = ~q + {{(QW-1){1'b0}}, 1'b1};
    if (sd.dir_zero) begin
      if (sd.num_pos) r = VMAX;
      else if (sd.num_neg) r = VMIN;
      else r = zero_is_max ? VMAX : VMIN;
    end else if (sd.q_neg) begin
      if (ovf || q > {2'b01, {(QW-2){1'b0}}}) r = VMIN;
      else r = $signed(qn[VW-1:0]);
    end else begin
      if (ovf || q[QW-1] || q[QW-2]) r = VMAX;
      else r = $signed(q[VW-1:0]);
    end
    return r;
  endfunction
endpackage

/* rtl/rbst_div_cell.sv */
// One restoring division cell: one quotient bit per cycle, registered.
// Depends on rbst_pkg.
module rbst_div_cell import rbst_pkg::*; #(
  parameter int NW = 49
) (
  input  logic          clk,
  input  logic [VW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [QW-1:0] q_i,
  input  logic          ovf_i,
  input  logic [VW-1:0] dvs_i,
  input  side_t         side_i,
  output logic [VW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [QW-1:0] q_o,
  output logic          ovf_o,
  output logic [VW-1:0] dvs_o,
  output side_t         side_o
);
  logic [VW:0] r2;
  logic [VW:0] diff;
  logic        ge;

  assign r2   = {rem_i, num_i[NW-1]};
  assign ge   = r2 >= {1'b0, dvs_i};
  assign diff = r2 - {1'b0, dvs_i};

  always_ff @(posedge clk) begin
    rem_o  <= ge ? diff[VW-1:0] : r2[VW-1:0];
    num_o  <= {num_i[NW-2:0], 1'b0};
    q_o    <= {q_i[QW-2:0], ge};
    ovf_o  <= ovf_i | q_i[QW-1];
    dvs_o  <= dvs_i;
    side_o <= side_i;
  end
endmodule

/* rtl/rbst_div_chain.sv */
// Chain of division cells for one plane distance magnitude.
// Depends on rbst_pkg and rbst_div_cell.
module rbst_div_chain import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] num,
  input  logic signed [VW-1:0] dir,
  output logic [QW-1:0]        q,
  output logic                 ovf,
  output side_t                side
);
  localparam int NW = DW + FRAC_BITS;

  logic [DW-1:0] num_mag;
  logic [VW-1:0] dir_mag;
  logic [VW-1:0] rem_a  [0:NW];
  logic [NW-1:0] num_a  [0:NW];
  logic [QW-1:0] q_a    [0:NW];
  logic          ovf_a  [0:NW];
  logic [VW-1:0] dvs_a  [0:NW];
  side_t         side_a [0:NW];

  assign num_mag   = num[DW-1] ? (~num + {{(DW-1){1'b0}}, 1'b1}) : num;
  assign dir_mag   = dir[VW-1] ? (~dir + {{(VW-1){1'b0}}, 1'b1}) : dir;
  assign rem_a[0]  = '0;
  assign num_a[0]  = {num_mag, {FRAC_BITS{1'b0}}};
  assign q_a[0]    = '0;
  assign ovf_a[0]  = 1'b0;
  assign dvs_a[0]  = dir_mag;
  assign side_a[0] = '{dir_zero: (dir == '0),
                       num_pos:  (!num[DW-1] && num != '0),
                       num_neg:  num[DW-1],
                       q_neg:    num[DW-1] ^ dir[VW-1]};

  for (genvar i = 0; i < NW; i++) begin : g_cell
    rbst_div_cell #(.NW(NW)) u_cell (
      .clk   (clk),
      .rem_i (rem_a[i]),   .num_i (num_a[i]),   .q_i (q_a[i]),
      .ovf_i (ovf_a[i]),   .dvs_i (dvs_a[i]),   .side_i (side_a[i]),
      .rem_o (rem_a[i+1]), .num_o (num_a[i+1]), .q_o (q_a[i+1]),
      .ovf_o (ovf_a[i+1]), .dvs_o (dvs_a[i+1]), .side_o (side_a[i+1])
    );
  end

  assign q    = q_a[NW];
  assign ovf  = ovf_a[NW];
  assign side = side_a[NW];
endmodule

/* rtl/ray_box_slab_test_top.sv */
// Ray against axis-aligned box, slab method, signed fixed point.
// Depends on rbst_pkg, rbst_div_chain and ray_box_slab_test_top_defines.svh.
// A new ray is taken every cycle (busy stays low); its result appears with
// done high after one register stage, one divider cell per numerator bit
// (33 + FRAC_BITS cells) and four finish stages.
// The receiver cannot stall: take hit and t_entry in the cycle done is high.
// Write the box registers only while no ray is in flight.
`include "ray_box_slab_test_top_defines.svh"
module ray_box_slab_test_top import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [VW-1:0]        cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [VW-1:0] origin_x,
  input  logic signed [VW-1:0] origin_y,
  input  logic signed [VW-1:0] origin_z,
  input  logic signed [VW-1:0] dir_x,
  input  logic signed [VW-1:0] dir_y,
  input  logic signed [VW-1:0] dir_z,
  output logic                 done,
  output logic                 hit,
  output logic signed [VW-1:0] t_entry
);
  localparam int NW = DW + FRAC_BITS;

  logic signed [VW-1:0] box_lo [0:2];
  logic signed [VW-1:0] box_hi [0:2];
  logic signed [VW-1:0] org    [0:2];
  logic signed [VW-1:0] dirv   [0:2];
  logic signed [DW-1:0] s0_lo  [0:2];
  logic signed [DW-1:0] s0_hi  [0:2];
  logic signed [VW-1:0] s0_dir [0:2];
  logic                 s0_v;
  logic [NW+2:0]        vdelay;
  logic [QW-1:0]        q_lo   [0:2];
  logic [QW-1:0]        q_hi   [0:2];
  logic                 ovf_lo [0:2];
  logic                 ovf_hi [0:2];
  side_t                sd_lo  [0:2];
  side_t                sd_hi  [0:2];
  logic signed [VW-1:0] t_lo   [0:2];
  logic signed [VW-1:0] t_hi   [0:2];
  logic signed [VW-1:0] tn     [0:2];
  logic signed [VW-1:0] tf     [0:2];
  logic signed [VW-1:0] near_r;
  logic signed [VW-1:0] far_r;
  logic signed [VW-1:0] near_next;
  logic signed [VW-1:0] far_next;

  assign busy = 1'b0;
  assign org  = '{origin_x, origin_y, origin_z};
  assign dirv = '{dir_x, dir_y, dir_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BOX_MIN_X: box_lo[0] <= cfg_wdata;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_wdata;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_wdata;
        REG_BOX_MAX_X: box_hi[0] <= cfg_wdata;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_wdata;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v   <= 1'b0;
      vdelay <= '0;
      done   <= 1'b0;
    end else begin
      s0_v   <= start && !busy;
      vdelay <= {vdelay[NW+1:0], s0_v};
      done   <= vdelay[NW+2];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s0_lo[i]  <= DW'(box_lo[i]) - DW'(org[i]);
      s0_hi[i]  <= DW'(box_hi[i]) - DW'(org[i]);
      s0_dir[i] <= dirv[i];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbst_div_chain #(.FRAC_BITS(FRAC_BITS)) u_lo (
      .clk (clk), .num (s0_lo[a]), .dir (s0_dir[a]),
      .q (q_lo[a]), .ovf (ovf_lo[a]), .side (sd_lo[a])
    );
    rbst_div_chain #(.FRAC_BITS(FRAC_BITS)) u_hi (
      .clk (clk), .num (s0_hi[a]), .dir (s0_dir[a]),
      .q (q_hi[a]), .ovf (ovf_hi[a]), .side (sd_hi[a])
    );
  end

  always_comb begin
    near_next = tn[0];
    far_next  = tf[0];
    for (int i = 1; i < 3; i++) begin
      if (tn[i] > near_next) near_next = tn[i];
      if (tf[i] < far_next) far_next = tf[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_lo[i] <= plane_t(q_lo[i], ovf_lo[i], sd_lo[i], 1'b0);
      t_hi[i] <= plane_t(q_hi[i], ovf_hi[i], sd_hi[i], 1'b1);
      tn[i]   <= (t_lo[i] < t_hi[i]) ? t_lo[i] : t_hi[i];
      tf[i]   <= (t_lo[i] < t_hi[i]) ? t_hi[i] : t_lo[i];
    end
    near_r  <= near_next;
    far_r   <= far_next;
    hit     <= near_r <= far_r;
    t_entry <= (near_r <= far_r) ? near_r : '0;
  end

  `RBST_ASSERT_IMPL(a_miss_zero, done && !hit, t_entry == '0)
  `RBST_ASSERT_NEXT(a_accept_enters, start && !busy, s0_v)
  `RBST_ASSERT_NEXT(a_last_stage_done, vdelay[NW+2], done)
  `RBST_ASSERT_NEXT(a_hit_order, vdelay[NW+2], hit == ($past(near_r) <= $past(far_r)))
endmodule
